### src/schal_pkg.sv
// ----------------------------------------------------------------------------
// schal_pkg
// Shared types and constants of the size-class heap allocator.
// ----------------------------------------------------------------------------
package schal_pkg;

    localparam int unsigned NUM_BINS     = 24;
    localparam int unsigned SMALL_BINS   = 8;
    localparam int unsigned BIN_W        = 5;
    localparam int unsigned PAGE_SHIFT   = 12;
    localparam int unsigned GRAN_SHIFT   = 4;
    localparam logic [16:0] MAX_ELEM     = 17'h10000;

    // request kind
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_LARGE = 3'd1;
    localparam logic [2:0] ST_EXHAUSTED = 3'd2;
    localparam logic [2:0] ST_RANGE     = 3'd3;
    localparam logic [2:0] ST_NOT_ALLOC = 3'd4;

    typedef struct packed {
        logic        func;
        logic [19:0] req_size;
        logic [16:0] alignment;
        logic [31:0] block_address;
    } req_t;

    typedef struct packed {
        logic [31:0] result_address;
        logic [2:0]  status;
        logic [4:0]  bin_used;
    } rsp_t;

    // element size of a bin in bytes
    function automatic logic [16:0] elem_size(input logic [4:0] bin);
        logic [16:0] es;
        if (bin < 5'(SMALL_BINS))
            es = 17'd16 << bin;
        else
            es = {bin - 5'd7, 12'd0};
        return es;
    endfunction

    // first bin that holds the size (size at most 64K)
    function automatic logic [4:0] pick_bin(input logic [16:0] size);
        logic [4:0] b;
        b = 5'd23;
        if (size <= 17'd2048)
        begin
            b = 5'd7;
            for (int i = 6; i >= 0; i--)
                if (size <= (17'd16 << i))
                    b = 5'(i);
        end
        else
        begin
            // 4K steps: ceil(size / 4096) + 7
            b = 5'(size[16:12] + ((size[11:0] != 12'd0) ? 5'd1 : 5'd0) + 5'd7);
        end
        return b;
    endfunction

endpackage

### src/schal_if.sv
// ----------------------------------------------------------------------------
// schal_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface schal_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### src/schal_ram.sv
// ----------------------------------------------------------------------------
// schal_ram
// Single-port-write, single-read synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module schal_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

### src/size_class_heap_allocator.sv
// ----------------------------------------------------------------------------
// size_class_heap_allocator
// Segregated-fit allocator: 24 size bins with LIFO free lists, chunks of
// whole pages carved from a bump pointer, and a per-granule allocated bitmap.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                   accepted when
//  req      in   func, req_size, alignment, block_address  valid & ready
//  rsp      out  result_address, status, bin_used          valid & ready
//  cfg      in   base address (32)                         cfg_we
//
// An allocate from the free list or a live chunk passes decode, read, done and
// alloc; when a new chunk is taken, the tag state first tags each of its pages
// (up to 16) before the read repeats. A free passes decode, read and free, heap
// full ends in read, and null, out of range or too large end in decode.
// After reset the bitmap is cleared, one granule per cycle, before the
// first request is taken.
// A request is taken while a result waits and holds in decode until the
// result register is free.
module size_class_heap_allocator #(
    parameter int unsigned HEAP_PAGES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    schal_if.sink       req,
    schal_if.source     rsp
);

    localparam int unsigned PG_W   = (HEAP_PAGES > 1) ? $clog2(HEAP_PAGES) : 1;
    localparam int unsigned NGRAN  = HEAP_PAGES * 256;
    localparam int unsigned GR_W   = $clog2(NGRAN);
    localparam int unsigned OFF_W  = GR_W + schal_pkg::GRAN_SHIFT;
    localparam int unsigned BUMP_W = OFF_W + 1;
    localparam int unsigned CNT_W  = GR_W + 1;
    localparam logic [BUMP_W-1:0] HEAP_BYTES = BUMP_W'(NGRAN) << schal_pkg::GRAN_SHIFT;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_READ, S_ALLOC, S_TAG, S_FREE, S_DONE
    } state_t;

    // granule word: mark bit plus free link
    localparam int unsigned GW = OFF_W + 1;

    state_t              state_reg;
    logic [31:0]         base_reg;
    logic [BUMP_W-1:0]   bump_reg;
    logic [GR_W-1:0]     clr_reg;
    schal_pkg::req_t     rq_reg;
    logic [4:0]          bin_reg;
    logic [OFF_W-1:0]    off_reg;
    logic [4:0]          tag_left_reg;
    logic [PG_W-1:0]     tag_pg_reg;
    schal_pkg::rsp_t     out_reg;
    logic                out_valid_reg;

    // per-bin registers (small, fixed 24 entries)
    logic [OFF_W-1:0]    head_reg  [schal_pkg::NUM_BINS];
    logic [CNT_W-1:0]    count_reg [schal_pkg::NUM_BINS];
    logic [OFF_W-1:0]    carve_reg [schal_pkg::NUM_BINS];
    logic [8:0]          left_reg  [schal_pkg::NUM_BINS];

    // granule memory
    logic                g_we;
    logic [GR_W-1:0]     g_waddr, g_raddr;
    logic [GW-1:0]       g_wdata, g_rdata;
    // page tag memory
    logic                t_we;
    logic [PG_W-1:0]     t_waddr, t_raddr;
    logic [4:0]          t_rdata;

    schal_ram #(.WIDTH(GW), .DEPTH(NGRAN)) u_gran (
        .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
        .raddr(g_raddr), .rdata(g_rdata)
    );
    schal_ram #(.WIDTH(5), .DEPTH(HEAP_PAGES)) u_tag (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(bin_reg),
        .raddr(t_raddr), .rdata(t_rdata)
    );

    // request decode
    logic [16:0]       eff_size;
    logic              too_large;
    logic [16:0]       es;
    logic [31:0]       foff;
    logic [BUMP_W-1:0] grow;
    logic              exhausted;
    logic [19:0]       sz_max;

    always_comb
    begin
        sz_max    = (rq_reg.req_size < 20'(rq_reg.alignment)) ? 20'(rq_reg.alignment)
                                                              : rq_reg.req_size;
        too_large = sz_max > 20'(schal_pkg::MAX_ELEM);
        eff_size  = sz_max[16:0];
        es        = schal_pkg::elem_size(bin_reg);
        foff      = rq_reg.block_address - base_reg;
        grow      = (bin_reg < 5'(schal_pkg::SMALL_BINS)) ? BUMP_W'(4096) : BUMP_W'(es);
        exhausted = (bump_reg > HEAP_BYTES) || (grow > HEAP_BYTES - bump_reg);
    end

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    // memory port control
    always_comb
    begin
        g_we    = 1'b0;
        g_waddr = off_reg[OFF_W-1:schal_pkg::GRAN_SHIFT];
        g_wdata = '0;
        g_raddr = off_reg[OFF_W-1:schal_pkg::GRAN_SHIFT];
        t_we    = 1'b0;
        t_waddr = tag_pg_reg;
        t_raddr = off_reg[OFF_W-1:schal_pkg::PAGE_SHIFT];
        unique case (state_reg)
            S_CLEAR:
            begin
                g_we    = 1'b1;
                g_waddr = clr_reg;
            end
            S_ALLOC:
            begin
                // mark the granule, keep the link
                g_we    = 1'b1;
                g_wdata = {1'b1, g_rdata[OFF_W-1:0]};
            end
            S_FREE:
            begin
                g_we    = g_rdata[OFF_W] && (off_reg[3:0] == 4'd0);
                g_wdata = {1'b0, head_reg[t_rdata < 5'd24 ? t_rdata : 5'd0]};
            end
            S_TAG:
                t_we = 1'b1;
            default: ;
        endcase
    end

    logic [4:0] fbin;
    assign fbin = (t_rdata < 5'd24) ? t_rdata : 5'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            base_reg      <= '0;
            bump_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 24; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
                carve_reg[i] <= '0;
                left_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
                base_reg <= cfg_wdata;
            if (rsp.valid && rsp.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == GR_W'(NGRAN - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                    if (req.valid && req.ready)
                    begin
                        rq_reg    <= req.payload;
                        state_reg <= S_DECODE;
                    end
                S_DECODE:
                    // hold until the result register is free
                    if (!out_valid_reg)
                    begin
                        bin_reg <= schal_pkg::pick_bin(eff_size);
                        if (rq_reg.func == schal_pkg::FUNC_FREE)
                        begin
                            off_reg <= foff[OFF_W-1:0];
                            if (rq_reg.block_address == 32'd0)
                            begin
                                out_reg       <= '{32'd0, schal_pkg::ST_OK, 5'd0};
                                out_valid_reg <= 1'b1;
                                state_reg     <= S_IDLE;
                            end
                            else if (rq_reg.block_address < base_reg ||
                                     foff >= 32'(HEAP_BYTES))
                            begin
                                out_reg       <= '{32'd0, schal_pkg::ST_RANGE, 5'd0};
                                out_valid_reg <= 1'b1;
                                state_reg     <= S_IDLE;
                            end
                            else
                                state_reg <= S_READ;
                        end
                        else if (too_large)
                        begin
                            out_reg       <= '{32'd0, schal_pkg::ST_TOO_LARGE, 5'd0};
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                        else
                            state_reg <= S_READ;
                    end
                S_READ:
                begin
                    // allocate: offset, heap full or new chunk; free: read
                    if (rq_reg.func == schal_pkg::FUNC_FREE)
                        state_reg <= S_FREE;
                    else if (count_reg[bin_reg] != '0)
                    begin
                        off_reg   <= head_reg[bin_reg];
                        state_reg <= S_DONE;
                    end
                    else if (left_reg[bin_reg] != 9'd0)
                    begin
                        off_reg   <= carve_reg[bin_reg];
                        state_reg <= S_DONE;
                    end
                    else if (exhausted)
                    begin
                        out_reg       <= '{32'd0, schal_pkg::ST_EXHAUSTED, bin_reg};
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        // new chunk at the bump pointer
                        carve_reg[bin_reg] <= bump_reg[OFF_W-1:0];
                        left_reg[bin_reg]  <= (bin_reg < 5'(schal_pkg::SMALL_BINS))
                                              ? 9'(13'd4096 >> (bin_reg + 5'd4)) : 9'd1;
                        bump_reg     <= bump_reg + grow;
                        tag_pg_reg   <= bump_reg[OFF_W-1:schal_pkg::PAGE_SHIFT];
                        tag_left_reg <= 5'(grow >> schal_pkg::PAGE_SHIFT);
                        state_reg    <= S_TAG;
                    end
                end
                S_TAG:
                begin
                    tag_pg_reg   <= tag_pg_reg + 1'b1;
                    tag_left_reg <= tag_left_reg - 5'd1;
                    if (tag_left_reg == 5'd1)
                        state_reg <= S_READ;
                end
                S_DONE:
                    // memory data for off_reg now valid next cycle
                    state_reg <= S_ALLOC;
                S_ALLOC:
                begin
                    if (count_reg[bin_reg] != '0)
                    begin
                        head_reg[bin_reg]  <= g_rdata[OFF_W-1:0];
                        count_reg[bin_reg] <= count_reg[bin_reg] - 1'b1;
                    end
                    else
                    begin
                        carve_reg[bin_reg] <= carve_reg[bin_reg] + OFF_W'(es);
                        left_reg[bin_reg]  <= left_reg[bin_reg] - 9'd1;
                    end
                    out_reg       <= '{base_reg + 32'(off_reg), schal_pkg::ST_OK, bin_reg};
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                S_FREE:
                begin
                    if (g_rdata[OFF_W] && (off_reg[3:0] == 4'd0))
                    begin
                        head_reg[fbin]  <= off_reg;
                        count_reg[fbin] <= count_reg[fbin] + 1'b1;
                        out_reg         <= '{32'd0, schal_pkg::ST_OK, fbin};
                    end
                    else
                        out_reg <= '{32'd0, schal_pkg::ST_NOT_ALLOC, 5'd0};
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // a waiting result stays until taken
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rsp.ready |=> out_valid_reg)
        else $error("result dropped");
    // bump pointer never passes heap end
    a_bump: assert property (@(posedge clk) disable iff (!rst_n)
        bump_reg <= HEAP_BYTES)
        else $error("bump pointer past heap end");
    // ok allocate results are granule aligned relative to base
    a_align: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) && out_reg.status == schal_pkg::ST_OK &&
        out_reg.result_address != 32'd0
        |-> ((out_reg.result_address - base_reg) & 32'hF) == 32'd0)
        else $error("misaligned block");

endmodule
